### src/gled_pkg.sv
`timescale 1ns / 1ps

package gled_pkg;

	// defaults for the top level parameters
	localparam int DEF_MAX_COLS     = 64;
	localparam int DEF_MAX_ROWS     = 64;
	localparam int DEF_SAMPLE_WIDTH = 16;

	// register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_FRAME_COLS = 1'b0;
	localparam logic REG_FRAME_ROWS = 1'b1;

	// peak count saturates at all ones
	localparam int PEAK_W = 12;
	localparam logic [PEAK_W-1:0] PEAK_LIMIT = '1;

	// entries of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// classification handed from front to back
	typedef struct packed {
		logic has_result; // interior cell, a result goes out
		logic peak;
		logic valley;
		logic frame_end;  // last interior cell of the frame
		logic clear;      // last sample of the frame: restart the peak count
	} cls_t;

endpackage

### src/gled_ram.sv
`timescale 1ns / 1ps

module gled_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/gled_front.sv
`timescale 1ns / 1ps

module gled_front #(
	parameter int MAX_COLS     = gled_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS     = gled_pkg::DEF_MAX_ROWS,
	parameter int SAMPLE_WIDTH = gled_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_COLS+1)-1:0]     frame_cols,
	input  logic [$clog2(MAX_ROWS+1)-1:0]     frame_rows,
	input  logic                              push,
	input  logic signed [SAMPLE_WIDTH-1:0]    elevation,
	output logic                              full,
	input  logic                              q_full,
	output logic                              q_push,
	output gled_pkg::cls_t                    q_flags,
	output logic [$clog2(MAX_ROWS)-1:0]       q_row,
	output logic [$clog2(MAX_COLS)-1:0]       q_col
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CSW = $clog2(MAX_COLS+1);
	localparam int RSW = $clog2(MAX_ROWS+1);
	localparam int SW  = SAMPLE_WIDTH;

	// sizes in use, saturated to 3..MAX
	logic [CSW-1:0] cols_used;
	logic [RSW-1:0] rows_used;

	always_comb begin
		if (frame_cols < CSW'(3)) begin
			cols_used = CSW'(3);
		end else if (frame_cols > CSW'(MAX_COLS)) begin
			cols_used = CSW'(MAX_COLS);
		end else begin
			cols_used = frame_cols;
		end
		if (frame_rows < RSW'(3)) begin
			rows_used = RSW'(3);
		end else if (frame_rows > RSW'(MAX_ROWS)) begin
			rows_used = RSW'(MAX_ROWS);
		end else begin
			rows_used = frame_rows;
		end
	end

	// raster position of the next sample
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CSW-1:0] c_x, c_nx;
	logic [RSW-1:0] r_x, r_nx;
	logic           eor, eof, prod, fend;

	assign c_x  = CSW'(col_q);
	assign c_nx = c_x + CSW'(1);
	assign r_x  = RSW'(row_q);
	assign r_nx = r_x + RSW'(1);
	assign eor  = c_nx >= cols_used;
	assign eof  = eor && (r_nx >= rows_used);
	assign prod = (col_q >= CW'(2)) && (row_q >= RW'(2)) &&
	              (c_x < cols_used) && (r_x < rows_used);
	assign fend = (c_nx == cols_used) && (r_nx == rows_used);

	// stage 1: sample waits for its line buffer read
	logic                 valid_s1;
	logic signed [SW-1:0] sample_s1;
	logic [CW-1:0]        col_s1;
	logic [RW-1:0]        row_s1;
	gled_pkg::cls_t       flags_s1;
	logic                 accept, adv, needs_q;

	assign needs_q = flags_s1.has_result || flags_s1.clear;
	assign adv     = valid_s1 && (!needs_q || !q_full);
	assign full    = valid_s1 && !adv;
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (eof) begin
					col_q <= '0;
					row_q <= '0;
				end else if (eor) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1           <= elevation;
			col_s1              <= col_q;
			row_s1              <= row_q;
			flags_s1.has_result <= prod;
			flags_s1.peak       <= 1'b0;
			flags_s1.valley     <= 1'b0;
			flags_s1.frame_end  <= fend;
			flags_s1.clear      <= eof;
		end
	end

	// both line buffers share one word: upper half two rows up, lower half one row up
	logic [2*SW-1:0] rd_word;

	gled_ram #(
		.WIDTH (2*SW),
		.DEPTH (MAX_COLS)
	) u_lines (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1),
		.wdata ({rd_word[SW-1:0], sample_s1}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_word)
	);

	// window: [0]/[1] top row, [2]/[3] middle row, [4]/[5] bottom row; [3] is the center
	logic signed [SW-1:0] win_q [6];
	logic signed [SW-1:0] top_v, mid_v, ctr_v;
	logic                 peak, valley;

	assign top_v = rd_word[2*SW-1:SW];
	assign mid_v = rd_word[SW-1:0];
	assign ctr_v = win_q[3];

	assign peak = (ctr_v >= win_q[0]) && (ctr_v >= win_q[1]) && (ctr_v >= top_v) &&
	              (ctr_v >= win_q[2]) && (ctr_v >= mid_v) &&
	              (ctr_v >= win_q[4]) && (ctr_v >= win_q[5]) && (ctr_v >= sample_s1);
	assign valley = (ctr_v <= win_q[1]) && (ctr_v <= win_q[5]) &&
	                (ctr_v <= win_q[2]) && (ctr_v <= mid_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top_v;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_v;
			win_q[4] <= win_q[5];
			win_q[5] <= sample_s1;
		end
	end

	always_comb begin
		q_flags        = flags_s1;
		q_flags.peak   = peak;
		q_flags.valley = valley;
	end

	assign q_push = adv && needs_q;
	assign q_row  = row_s1 - RW'(1);
	assign q_col  = col_s1 - CW'(1);

endmodule

### src/gled_fifo.sv
`timescale 1ns / 1ps

module gled_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = gled_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = cnt_q == NW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

### src/gled_back.sv
`timescale 1ns / 1ps

module gled_back #(
	parameter int MAX_COLS = gled_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gled_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  gled_pkg::cls_t                 q_flags,
	input  logic [$clog2(MAX_ROWS)-1:0]    q_row,
	input  logic [$clog2(MAX_COLS)-1:0]    q_col,
	output logic                           q_pop,
	input  logic                           pop,
	output logic                           empty,
	output logic [$clog2(MAX_ROWS)-1:0]    center_row,
	output logic [$clog2(MAX_COLS)-1:0]    center_col,
	output logic                           is_peak,
	output logic                           is_valley,
	output logic [gled_pkg::PEAK_W-1:0]    peak_total,
	output logic                           frame_end
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);

	logic                        out_valid_q;
	logic [gled_pkg::PEAK_W-1:0] cnt_q, cnt_new;
	logic                        slot_free, load, inc;

	assign slot_free = !out_valid_q || pop;
	assign q_pop     = !q_empty && (!q_flags.has_result || slot_free);
	assign load      = q_pop && q_flags.has_result;
	assign inc       = load && q_flags.peak && (cnt_q != gled_pkg::PEAK_LIMIT);
	assign cnt_new   = cnt_q + gled_pkg::PEAK_W'(inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cnt_q <= q_flags.clear ? '0 : cnt_new;
			end
		end
	end

	logic [RW-1:0]               row_q;
	logic [CW-1:0]               col_q;
	logic                        peak_q, valley_q, fend_q;
	logic [gled_pkg::PEAK_W-1:0] total_q;

	always_ff @(posedge clk) begin
		if (load) begin
			row_q    <= q_row;
			col_q    <= q_col;
			peak_q   <= q_flags.peak;
			valley_q <= q_flags.valley;
			fend_q   <= q_flags.frame_end;
			total_q  <= cnt_new;
		end
	end

	assign empty      = !out_valid_q;
	assign center_row = row_q;
	assign center_col = col_q;
	assign is_peak    = peak_q;
	assign is_valley  = valley_q;
	assign peak_total = total_q;
	assign frame_end  = fend_q;

endmodule

### src/grid_local_extrema_detector.sv
`timescale 1ns / 1ps

// Local extrema detector over a raster elevation grid (3x3 peaks, 4-neighbor valleys).
// Input channel: one signed sample per transfer (push while full is low),
// raster order, frame_cols samples per row, frame_rows rows per frame.
// Result channel: one result per interior cell, shown while empty is low and
// taken with pop. Border cells give no transfer. A cell's result leaves once
// the sample below and right of it has arrived.
// Path: an accepted sample waits in stage 1 for its line buffer read, then its
// result passes through the queue into the output register on the ports.
// Throughput: one sample per clock while full stays low; the line buffer memory is read
// once and written once per sample on separate ports.
// A four entry queue plus the output register absorb receiver stalls; full
// rises only once all of them are occupied, and nothing is dropped.
// Reset: position and peak count go to zero, sizes to MAX_COLSxMAX_ROWS (64x64 by default),
// the queue and output register empty. Line buffer contents are unknown until two rows fill.
// Registers (APB, byte address 0: frame_cols, 4: frame_rows): the user must write them
// only while the block is idle, which is unchecked; sizes outside 3..MAX are saturated when used.
// peak_total counts peaks of the current frame, saturating at 4095.
module grid_local_extrema_detector #(
	parameter int MAX_COLS     = gled_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS     = gled_pkg::DEF_MAX_ROWS,
	parameter int SAMPLE_WIDTH = gled_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [gled_pkg::PADDR_W-1:0]     paddr,
	input  logic [gled_pkg::PDATA_W-1:0]     pwdata,
	output logic [gled_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	// sample channel
	input  logic                             push,
	input  logic signed [SAMPLE_WIDTH-1:0]   elevation,
	output logic                             full,
	// result channel
	input  logic                             pop,
	output logic                             empty,
	output logic [$clog2(MAX_ROWS)-1:0]      center_row,
	output logic [$clog2(MAX_COLS)-1:0]      center_col,
	output logic                             is_peak,
	output logic                             is_valley,
	output logic [gled_pkg::PEAK_W-1:0]      peak_total,
	output logic                             frame_end
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CSW = $clog2(MAX_COLS+1);
	localparam int RSW = $clog2(MAX_ROWS+1);
	localparam int FW  = $bits(gled_pkg::cls_t);
	localparam int QW  = RW + CW + FW;

	// ---------------------------------------------------------------
	// Configuration registers: raw values, read back as written
	// ---------------------------------------------------------------
	logic [CSW-1:0] frame_cols_q;
	logic [RSW-1:0] frame_rows_q;
	logic           cfg_wr;
	logic           reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[gled_pkg::REG_IDX_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= CSW'(MAX_COLS);
			frame_rows_q <= RSW'(MAX_ROWS);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gled_pkg::REG_FRAME_COLS: frame_cols_q <= pwdata[CSW-1:0];
				gled_pkg::REG_FRAME_ROWS: frame_rows_q <= pwdata[RSW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			gled_pkg::REG_FRAME_COLS: prdata = gled_pkg::PDATA_W'(frame_cols_q);
			gled_pkg::REG_FRAME_ROWS: prdata = gled_pkg::PDATA_W'(frame_rows_q);
			default:                  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Front: position tracking, line buffers, window and compares
	// ---------------------------------------------------------------
	logic           q_full, q_push, q_pop, q_empty;
	gled_pkg::cls_t f_flags, b_flags;
	logic [RW-1:0]  f_row, b_row;
	logic [CW-1:0]  f_col, b_col;
	logic [QW-1:0]  q_rd;

	gled_front #(
		.MAX_COLS     (MAX_COLS),
		.MAX_ROWS     (MAX_ROWS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_cols (frame_cols_q),
		.frame_rows (frame_rows_q),
		.push       (push),
		.elevation  (elevation),
		.full       (full),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_flags    (f_flags),
		.q_row      (f_row),
		.q_col      (f_col)
	);

	// ---------------------------------------------------------------
	// Queue between front and back: classified cells and frame restarts
	// ---------------------------------------------------------------
	gled_fifo #(
		.WIDTH (QW),
		.DEPTH (gled_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data ({f_row, f_col, f_flags}),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	assign b_flags = q_rd[FW-1:0];
	assign b_col   = q_rd[FW+CW-1:FW];
	assign b_row   = q_rd[QW-1:FW+CW];

	// ---------------------------------------------------------------
	// Back: peak count and the result register
	// ---------------------------------------------------------------
	gled_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_flags    (b_flags),
		.q_row      (b_row),
		.q_col      (b_col),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.center_row (center_row),
		.center_col (center_col),
		.is_peak    (is_peak),
		.is_valley  (is_valley),
		.peak_total (peak_total),
		.frame_end  (frame_end)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// front never pushes into a full queue (its stall must cover this)
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	// back only drains a queue that holds something
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	// a peak result always carries a nonzero count
	a_peak_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_peak) |-> (peak_total != '0))
		else $error("peak result with zero peak count");

	// a frame end entry always clears the count behind it
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && b_flags.frame_end) |-> b_flags.clear)
		else $error("frame end without count restart");

endmodule
